FILE: sv/pctu_pkg.sv
// Package with the shared types, character codes and helpers of the percent unescape unit.
package pctu_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_LOWER_U = 8'h75;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] CONT_BYTE  = 8'h80;

  // Depth of the result queue, in groups of up to three bytes.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PCT  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_U0   = 3'd3,
    PH_U1   = 3'd4,
    PH_U2   = 3'd5,
    PH_U3   = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [11:0] acc;
  } parse_state_t;

  // The bytes that one input beat produces, first byte in slot 0.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } result_group_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      n = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

FILE: sv/pctu_if.sv
// Stream interfaces for the escaped text input and the decoded byte output.
interface pctu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface pctu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: sv/percent_unicode_unescape_to_utf8_unit.sv
// Top level of the percent and %u unescaper that turns escaped text into UTF-8 bytes.
//
//   channel   role    beat carries                 accepted when
//   text      sink    text_byte, end_of_text       text.valid and text.ready
//   decoded   source  out_byte, run_last           decoded.valid and decoded.ready
//   cfg       write   cfg_data (comma newline on)  cfg_write
//
// An input beat is taken in every cycle in which the result queue has room for
// one more group. The parser state sits in registers and the decode of a beat
// is a single pass of combinational logic whose result group, of up to three
// bytes, is written into the queue at the same edge; its first byte can leave
// on the following cycle. Output runs at one byte per cycle while the receiver
// is ready, so a beat that yields two or three bytes holds the queue head until
// all of them have left, and the four-group queue absorbs such bursts. Reset is
// synchronous and puts the parser at idle, empties the queue and sets comma
// newline insertion on. A stalled output only stops input once the queue is full.
module percent_unicode_unescape_to_utf8_unit (
  input logic       clk,
  input logic       rst,
  pctu_in_if.sink   text,
  pctu_out_if.source decoded,
  input logic       cfg_write,
  input logic       cfg_data
);
  import pctu_pkg::*;

  parse_state_t  state;
  parse_state_t  state_next;
  result_group_t group;
  logic          comma_newline_enable;
  logic          queue_full;
  logic          accept;

  // The sole configuration register is written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      comma_newline_enable <= 1'b1;
    end else if (cfg_write) begin
      comma_newline_enable <= cfg_data;
    end
  end

  assign text.ready = !queue_full;
  assign accept     = text.valid && text.ready;

  pctu_decode u_decode (
    .state                (state),
    .text_byte            (text.text_byte),
    .end_of_text          (text.end_of_text),
    .comma_newline_enable (comma_newline_enable),
    .state_next           (state_next),
    .group                (group)
  );

  // The parser only moves on an accepted beat; bytes inside an open escape
  // produce an empty group, which is not queued.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.acc   <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  pctu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && (group.count != 2'd0)),
    .push_group (group),
    .full       (queue_full),
    .decoded    (decoded)
  );

endmodule

FILE: sv/pctu_decode.sv
// Combinational escape parser: next parser state and the result bytes of one input byte.
module pctu_decode (
  input  pctu_pkg::parse_state_t  state,
  input  logic [7:0]              text_byte,
  input  logic                    end_of_text,
  input  logic                    comma_newline_enable,
  output pctu_pkg::parse_state_t  state_next,
  output pctu_pkg::result_group_t group
);
  import pctu_pkg::*;

  logic [3:0]  nib;
  logic [7:0]  hex_byte;
  logic [15:0] cp;
  logic        emit_plain;
  logic [7:0]  plain_byte;

  assign nib      = nibble_of(text_byte);
  assign hex_byte = {state.acc[3:0], nib};
  assign cp       = {state.acc, nib};

  always_comb begin
    state_next  = state;
    emit_plain  = 1'b0;
    plain_byte  = text_byte;
    group.count = 2'd0;
    group.bytes = '0;
    case (state.phase)
      PH_IDLE: begin
        if (text_byte == CHAR_PERCENT) begin
          state_next.phase = PH_PCT;
          state_next.acc   = '0;
        end else begin
          emit_plain = 1'b1;
        end
      end
      PH_PCT: begin
        if (text_byte == CHAR_LOWER_U) begin
          state_next.phase = PH_U0;
          state_next.acc   = '0;
        end else begin
          state_next.phase = PH_HEX1;
          state_next.acc   = {8'd0, nib};
        end
      end
      PH_HEX1: begin
        emit_plain       = 1'b1;
        plain_byte       = hex_byte;
        state_next.phase = PH_IDLE;
        state_next.acc   = '0;
      end
      PH_U0: begin
        state_next.phase = PH_U1;
        state_next.acc   = {state.acc[7:0], nib};
      end
      PH_U1: begin
        state_next.phase = PH_U2;
        state_next.acc   = {state.acc[7:0], nib};
      end
      PH_U2: begin
        state_next.phase = PH_U3;
        state_next.acc   = {state.acc[7:0], nib};
      end
      PH_U3: begin
        state_next.phase = PH_IDLE;
        state_next.acc   = '0;
        if (cp[15:11] != 5'd0) begin
          group.count    = 2'd3;
          group.bytes[0] = LEAD_THREE | {4'd0, cp[15:12]};
          group.bytes[1] = CONT_BYTE | {2'd0, cp[11:6]};
          group.bytes[2] = CONT_BYTE | {2'd0, cp[5:0]};
        end else if (cp[10:7] != 4'd0) begin
          group.count    = 2'd2;
          group.bytes[0] = LEAD_TWO | {3'd0, cp[10:6]};
          group.bytes[1] = CONT_BYTE | {2'd0, cp[5:0]};
        end else begin
          group.count    = 2'd1;
          group.bytes[0] = cp[7:0];
        end
      end
      default: begin
        state_next.phase = PH_IDLE;
        state_next.acc   = '0;
        emit_plain       = 1'b1;
      end
    endcase

    if (emit_plain) begin
      group.bytes[0] = plain_byte;
      if (plain_byte == CHAR_COMMA && comma_newline_enable) begin
        group.count    = 2'd2;
        group.bytes[1] = CHAR_NEWLINE;
      end else begin
        group.count = 2'd1;
      end
    end

    if (end_of_text) begin
      state_next.phase = PH_IDLE;
      state_next.acc   = '0;
    end
  end

endmodule

FILE: sv/pctu_queue.sv
// Queue of result groups with a serialiser that sends one byte per output beat.
module pctu_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pctu_pkg::result_group_t push_group,
  output logic                    full,
  pctu_out_if.source              decoded
);
  import pctu_pkg::*;

  result_group_t       store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic [1:0]          byte_sel;
  result_group_t       head;
  logic                pop_byte;
  logic                pop_group;

  assign head      = store[rd_ptr];
  assign full      = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_byte  = decoded.valid && decoded.ready;
  assign pop_group = pop_byte && decoded.run_last;

  assign decoded.valid    = (fill != '0);
  assign decoded.out_byte = head.bytes[byte_sel];
  assign decoded.run_last = (byte_sel == head.count - 2'd1);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      byte_sel <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_group) begin
        rd_ptr   <= rd_ptr + 1'b1;
        byte_sel <= '0;
      end else if (pop_byte) begin
        byte_sel <= byte_sel + 2'd1;
      end
      case ({push, pop_group})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: dv/tb_percent_unicode_unescape_to_utf8_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the percent and %u unescaper with UTF-8 output.
module tb_percent_unicode_unescape_to_utf8_unit;
  import pctu_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  // The limit leaves ample margin above the longest stall of a correct run.
  localparam int WATCHDOG_LIMIT = 2000;
  // A beat that opens an escape produces nothing, so allow the pipeline to
  // settle after the last expected byte before a register write.
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_UPPER_G = 8'h47;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  // One decoded byte as the output channel carries it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } decoded_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  pctu_in_if  text_if ();
  pctu_out_if dec_if ();

  percent_unicode_unescape_to_utf8_unit dut (
    .clk      (clk),
    .rst      (rst),
    .text     (text_if),
    .decoded  (dec_if),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder state as the testbench sees it. It advances once per accepted
  // input beat, and the bytes that each beat produces are queued in order.
  phase_t        parse_phase_m = PH_IDLE;
  logic [15:0]   hex_acc_m = 16'h0000;
  logic          comma_nl_m = 1'b1;
  decoded_beat_t expected_bytes[$];

  int  mismatch_count = 0;
  int  beats_sent = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  rx_hold_request = 0;
  int  rx_hold_left = 0;
  int  quiet_cycles = 0;

  // Value of a hex digit; anything that is not a digit counts as zero.
  function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 4'(c - CHAR_ZERO);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return 4'(c - CHAR_UPPER_A + 8'd10);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return 4'(c - CHAR_LOWER_A + 8'd10);
    return 4'd0;
  endfunction

  // Advances the decoder state by one text byte and queues the bytes it yields.
  function automatic void predict_text_byte(input logic [7:0] c, input logic eot);
    logic [7:0]  group[$];
    logic        emit_plain;
    logic [7:0]  plain;
    logic [15:0] cp;
    emit_plain = 1'b0;
    plain = c;
    case (parse_phase_m)
      PH_IDLE: begin
        if (c == CHAR_PERCENT) begin
          parse_phase_m = PH_PCT;
          hex_acc_m = 16'h0000;
        end else begin
          emit_plain = 1'b1;
        end
      end
      PH_PCT: begin
        // Only a lower-case u opens a code point; anything else is the first digit.
        if (c == CHAR_LOWER_U) begin
          parse_phase_m = PH_U0;
          hex_acc_m = 16'h0000;
        end else begin
          parse_phase_m = PH_HEX1;
          hex_acc_m = {12'h000, hex_digit_value(c)};
        end
      end
      PH_HEX1: begin
        plain = {hex_acc_m[3:0], hex_digit_value(c)};
        emit_plain = 1'b1;
        parse_phase_m = PH_IDLE;
        hex_acc_m = 16'h0000;
      end
      PH_U0, PH_U1, PH_U2: begin
        hex_acc_m = {hex_acc_m[11:0], hex_digit_value(c)};
        parse_phase_m = phase_t'(parse_phase_m + 3'd1);
      end
      PH_U3: begin
        cp = {hex_acc_m[11:0], hex_digit_value(c)};
        if (cp >= 16'h0800) begin
          group.push_back(LEAD_THREE | {4'h0, cp[15:12]});
          group.push_back(CONT_BYTE | {2'b00, cp[11:6]});
          group.push_back(CONT_BYTE | {2'b00, cp[5:0]});
        end else if (cp >= 16'h0080) begin
          group.push_back(LEAD_TWO | {3'b000, cp[10:6]});
          group.push_back(CONT_BYTE | {2'b00, cp[5:0]});
        end else begin
          // A comma that arrives as a code point gets no newline.
          group.push_back(cp[7:0]);
        end
        parse_phase_m = PH_IDLE;
        hex_acc_m = 16'h0000;
      end
      default: begin
        emit_plain = 1'b1;
        parse_phase_m = PH_IDLE;
        hex_acc_m = 16'h0000;
      end
    endcase
    if (emit_plain) begin
      group.push_back(plain);
      if (plain == CHAR_COMMA && comma_nl_m) group.push_back(CHAR_NEWLINE);
    end
    // The end of the text discards whatever escape is still open.
    if (eot) begin
      parse_phase_m = PH_IDLE;
      hex_acc_m = 16'h0000;
    end
    foreach (group[i]) begin
      expected_bytes.push_back('{out_byte: group[i], run_last: (i == group.size() - 1)});
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one text beat, idling first at the sender's rate, and returns at the
  // edge that accepts it. Ready is sampled at the falling edge, where it is stable.
  task automatic send_text_byte(input logic [7:0] c, input logic eot);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= c;
    text_if.end_of_text <= eot;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = text_if.ready;
      @(posedge clk);
    end
    predict_text_byte(c, eot);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input logic eot_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_text_byte(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  // Stops offering beats and waits until every expected byte has come out.
  task automatic wait_for_results();
    text_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_comma_newline(input logic enable);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= enable;
    @(posedge clk);
    cfg_write <= 1'b0;
    comma_nl_m = enable;
  endtask

  // Hex digit in random case, now and then replaced by a byte that is no digit.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if ($urandom_range(19) == 0) begin
      return ($urandom_range(3) == 0) ? CHAR_PERCENT : CHAR_UPPER_G + 8'($urandom_range(19));
    end
    if (v < 4'd10) return CHAR_ZERO + {4'h0, v};
    return ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + {4'h0, v} - 8'd10;
  endfunction

  // One random token: mostly well-formed escapes and plain text, with some raw
  // noise and escapes cut short by the end of the text.
  task automatic send_random_token();
    logic [7:0]  seq[$];
    logic [15:0] cp;
    logic        eot;
    int          kind;
    int          ndig;
    kind = $urandom_range(99);
    eot = ($urandom_range(9) == 0);
    if (kind < 25) begin
      seq.push_back(8'($urandom_range(255)));
      if (seq[0] == CHAR_PERCENT || $urandom_range(4) == 0) seq[0] = CHAR_COMMA;
    end else if (kind < 45) begin
      cp = ($urandom_range(3) == 0) ? {8'h00, CHAR_COMMA} : 16'($urandom_range(255));
      seq.push_back(CHAR_PERCENT);
      seq.push_back(hex_char(cp[7:4]));
      seq.push_back(hex_char(cp[3:0]));
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: cp = 16'($urandom_range(16'h007F));
        1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
        2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: cp = 16'($urandom_range(16'hFFFF));
      endcase
      seq.push_back(CHAR_PERCENT);
      seq.push_back(CHAR_LOWER_U);
      for (int i = 3; i >= 0; i--) seq.push_back(hex_char(cp[i*4 +: 4]));
    end else if (kind < 90) begin
      seq.push_back(8'($urandom_range(255)));
    end else begin
      // An escape that the end of the text cuts off.
      eot = 1'b1;
      seq.push_back(CHAR_PERCENT);
      if ($urandom_range(1)) begin
        seq.push_back(CHAR_LOWER_U);
        ndig = $urandom_range(3);
      end else begin
        ndig = $urandom_range(1);
      end
      for (int i = 0; i < ndig; i++) seq.push_back(hex_char(4'($urandom_range(15))));
    end
    foreach (seq[i]) send_text_byte(seq[i], eot && (i == seq.size() - 1));
  endtask

  // The receiver stalls at its rate, or holds off for a whole stretch on request.
  always @(posedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      dec_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      dec_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output beats are checked at the falling edge before the edge that takes them,
  // when every signal is stable. The watchdog counts cycles without any beat.
  always @(negedge clk) begin
    decoded_beat_t want;
    if (!rst) begin
      if (dec_if.valid && dec_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("out_byte with nothing expected", dec_if.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (dec_if.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", dec_if.out_byte, want.out_byte);
          end
          if (dec_if.run_last !== want.run_last) begin
            report_mismatch("run_last", {7'h00, dec_if.run_last}, {7'h00, want.run_last});
          end
        end
      end
      if ((dec_if.valid && dec_if.ready) || (text_if.valid && text_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d bytes outstanding", $time,
                 quiet_cycles, expected_bytes.size());
        $display("tb_percent_unicode_unescape_to_utf8_unit: FAIL");
        $finish;
      end
    end
  end

  // Plain bytes at both ends of the range and a comma, which may take a newline.
  task automatic test_plain_passthrough();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(CHAR_COMMA, 1'b0);
    wait_for_results();
  endtask

  // Two-digit escapes: a comma, mixed-case digits, and an upper-case U and a
  // percent sign in digit positions, both of which count as zero.
  task automatic test_two_digit_escapes();
    send_text("%2C", 1'b0);
    send_text("%fF", 1'b0);
    send_text("%U%", 1'b0);
    wait_for_results();
  endtask

  // Code points that need three, two and one bytes; the comma gets no newline.
  task automatic test_unicode_escapes();
    send_text("%u20AC", 1'b0);
    send_text("%u00e9", 1'b0);
    send_text("%u002C", 1'b0);
    wait_for_results();
  endtask

  // An escape still open at the end of the text is dropped and the parser
  // starts afresh with the next byte.
  task automatic test_unfinished_escape();
    send_text("%u", 1'b1);
    send_text("A", 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n);
    int first;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first = beats_sent;
    while (beats_sent - first < n) send_random_token();
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats, so the result queue fills and the input stalls.
  task automatic test_output_backpressure();
    int first;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_request = 150;
    while (rx_hold_left == 0) @(posedge clk);
    first = beats_sent;
    while (beats_sent - first < 30) send_random_token();
    wait_for_results();
  endtask

  initial begin
    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h00;
    text_if.end_of_text = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed checks with the sender idling lightly and the receiver heavily.
    tx_idle_pct = 19;
    rx_idle_pct = 77;
    write_comma_newline(1'b1);
    test_plain_passthrough();
    test_two_digit_escapes();
    test_unicode_escapes();
    test_unfinished_escape();
    test_random_traffic(19, 77, 55);

    // Newline insertion off, with the idling rates swapped.
    write_comma_newline(1'b0);
    test_plain_passthrough();
    test_random_traffic(77, 19, 55);

    // Back on, at full rate on both sides, then with the output held off.
    write_comma_newline(1'b1);
    test_random_traffic(0, 0, 55);
    test_output_backpressure();

    if (mismatch_count == 0) begin
      $display("tb_percent_unicode_unescape_to_utf8_unit: PASS");
    end else begin
      $display("tb_percent_unicode_unescape_to_utf8_unit: FAIL");
    end
    $finish;
  end

endmodule
